// ===== hw/rtl/acpi_scan_pkg.sv =====
// ============================================================================
// acpi_scan_pkg
// Shared types and constants for the ACPI I2C descriptor scanner.
// ============================================================================
package acpi_scan_pkg;

    // Window and field widths.
    localparam int C_WIN_DEPTH = 17;
    localparam int C_LEN_W     = 23;
    localparam int C_LEN16_W   = 16;

    // Descriptor header checks.
    localparam logic [7:0]         C_DESC_TAG        = 8'h8E;
    localparam logic [7:0]         C_BUS_TYPE_I2C    = 8'h01;
    localparam logic [C_LEN_W-1:0] C_MIN_OFFSET      = 23'd36;
    localparam logic [15:0]        C_MIN_PAYLOAD     = 16'd15;
    localparam logic [15:0]        C_MIN_TYPE_LEN    = 16'd6;
    localparam logic [7:0]         C_ADDR_LOW        = 8'h08;
    localparam logic [7:0]         C_ADDR_HIGH       = 8'h77;
    localparam logic [C_LEN_W-1:0] C_MAX_TABLE_BYTES = 23'd4194304;

    // Default depth of the result queue.
    localparam int C_QUEUE_DEPTH = 2;

    // One input beat.
    typedef struct packed {
        logic [7:0]         data_byte;
        logic [C_LEN_W-1:0] table_length;
        logic               first_byte;
        logic               last_byte;
    } t_item;

    // One result beat.
    typedef struct packed {
        logic       found;
        logic [6:0] slave_address;
    } t_result;

    // Result handed from the scanner to the queue.
    typedef struct packed {
        logic    valid;
        t_result result;
    } t_push;

endpackage

// ===== hw/rtl/acpi_scan_if.sv =====
// ============================================================================
// acpi_scan_if
// Valid/ready stream channel carrying one payload beat per handshake.
// ============================================================================
interface acpi_scan_if #(
    parameter type t_payload = logic [7:0]
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/acpi_scan_front.sv =====
// ============================================================================
// acpi_scan_front
// Byte window, position counter and descriptor header checks. Classifies each
// accepted byte and hands at most one result to the queue.
// ============================================================================
module acpi_scan_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  acpi_scan_pkg::t_item  i_item,
    output logic                  o_ready,
    input  logic                  i_space,
    output acpi_scan_pkg::t_push  o_push
);
    import acpi_scan_pkg::*;

    logic [7:0]         r_win [C_WIN_DEPTH];
    logic [7:0]         n_win [C_WIN_DEPTH];
    logic [C_LEN_W-1:0] r_pos, n_pos;
    logic               r_done, n_done;

    logic [7:0]         span [C_WIN_DEPTH+1];
    logic [C_LEN_W-1:0] pos_eff;
    logic               done_eff;
    logic               accept;
    logic [15:0]        payload_len;
    logic [15:0]        type_len;
    logic               len_ok, pos_ok, fit_ok, payload_ok, hdr_ok, addr_ok;
    logic               match;

    assign o_ready = i_space;
    assign accept  = i_valid & i_space;

    // A first byte sees a cleared window, position and done flag.
    always_comb begin
        pos_eff  = i_item.first_byte ? '0 : r_pos;
        done_eff = i_item.first_byte ? 1'b0 : r_done;
        for (int k = 0; k < C_WIN_DEPTH; k++) begin
            span[k] = i_item.first_byte ? 8'h00 : r_win[k];
        end
        span[C_WIN_DEPTH] = i_item.data_byte;
    end

    // Header checks on the span that starts 17 bytes back.
    always_comb begin
        payload_len = {span[2], span[1]};
        type_len    = {span[11], span[10]};
        len_ok      = (i_item.table_length >= C_MIN_OFFSET) &&
                      (i_item.table_length <= C_MAX_TABLE_BYTES);
        // Candidate offset is at least 36 and the span ends inside the table.
        pos_ok      = (pos_eff >= (C_MIN_OFFSET + C_LEN_W'(C_WIN_DEPTH))) &&
                      (pos_eff < i_item.table_length);
        // Payload end (offset + 3 + payload) must not pass the table length.
        fit_ok      = ({2'b00, pos_eff} + {9'd0, payload_len}) <=
                      ({2'b00, i_item.table_length} +
                       25'(C_WIN_DEPTH - 3));
        payload_ok  = (payload_len >= C_MIN_PAYLOAD) && fit_ok;
        hdr_ok      = (span[0] == C_DESC_TAG) && (span[5] == C_BUS_TYPE_I2C) &&
                      (type_len >= C_MIN_TYPE_LEN);
        addr_ok     = (span[17] == 8'h00) && (span[16] >= C_ADDR_LOW) &&
                      (span[16] <= C_ADDR_HIGH);
        match       = !done_eff && len_ok && pos_ok && payload_ok && hdr_ok &&
                      addr_ok;
    end

    // Result to the queue: a match, or not-found on the last byte.
    always_comb begin
        o_push.valid                = accept && (match ||
                                      (i_item.last_byte && !done_eff));
        o_push.result.found         = match;
        o_push.result.slave_address = match ? span[16][6:0] : 7'd0;
    end

    // Next window, position and done flag.
    always_comb begin
        for (int k = 0; k < C_WIN_DEPTH; k++) begin
            n_win[k] = r_win[k];
        end
        n_pos  = r_pos;
        n_done = r_done;
        if (accept) begin
            for (int k = 0; k < C_WIN_DEPTH; k++) begin
                n_win[k] = span[k+1];
            end
            n_pos  = (pos_eff == '1) ? pos_eff : pos_eff + 1'b1;
            n_done = done_eff | match | i_item.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < C_WIN_DEPTH; k++) begin
                r_win[k] <= 8'h00;
            end
            r_pos  <= '0;
            r_done <= 1'b0;
        end else begin
            for (int k = 0; k < C_WIN_DEPTH; k++) begin
                r_win[k] <= n_win[k];
            end
            r_pos  <= n_pos;
            r_done <= n_done;
        end
    end

endmodule

// ===== hw/rtl/acpi_scan_queue.sv =====
// ============================================================================
// acpi_scan_queue
// Small result queue between the scanner and the output channel. Its head
// drives the output beat directly from registers.
// ============================================================================
module acpi_scan_queue #(
    parameter int DEPTH = acpi_scan_pkg::C_QUEUE_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  acpi_scan_pkg::t_push    i_push,
    output logic                    o_space,
    output logic                    o_valid,
    output acpi_scan_pkg::t_result  o_result,
    input  logic                    i_ready
);
    import acpi_scan_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_result          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             pop;

    assign o_space  = (r_cnt != CNT_W'(DEPTH));
    assign o_valid  = (r_cnt != '0);
    assign o_result = r_mem[r_rd];
    assign pop      = o_valid & i_ready;

    // Pointer and fill count update.
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push.valid) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        unique case ({i_push.valid, pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.result;
        end
    end

endmodule

// ===== hw/rtl/acpi_i2c_descriptor_scanner_core.sv =====
// ============================================================================
// acpi_i2c_descriptor_scanner_core
// Scans a streamed ACPI table for the first valid I2C serial-bus descriptor
// and reports its slave address, or not-found at the end of the table.
// ============================================================================
//
//  Channel  Dir  Beat contents
//  -------  ---  ------------------------------------------------------------
//  i_in     in   data_byte, table_length, first_byte, last_byte
//  o_out    out  found, slave_address
//
//  One byte is accepted per cycle; its result, if any, is registered in the
//  result queue and shown on o_out once earlier results are taken. The
//  header checks on the 18-byte window are combinational.
//  Reset clears the window, the position counter and the result queue.
//  i_in stalls only when the result queue is full, so a stalled o_out holds
//  back input after QUEUE_DEPTH pending results.
module acpi_i2c_descriptor_scanner_core #(
    parameter int QUEUE_DEPTH = acpi_scan_pkg::C_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    acpi_scan_if.sink   i_in,
    acpi_scan_if.source o_out
);
    import acpi_scan_pkg::*;

    t_push   push;
    logic    space;
    t_result head;

    // Scanner: window, position and checks.
    acpi_scan_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_item  (i_in.payload),
        .o_ready (i_in.ready),
        .i_space (space),
        .o_push  (push)
    );

    // Result queue feeding the output channel.
    acpi_scan_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_space  (space),
        .o_valid  (o_out.valid),
        .o_result (head),
        .i_ready  (o_out.ready)
    );

    assign o_out.payload = head;

endmodule

// ===== bench/acpi_i2c_descriptor_scanner_core_tb.sv =====
// ============================================================================
// acpi_i2c_descriptor_scanner_core_tb
// Streams ACPI tables byte by byte into the scanner, with I2C serial-bus
// descriptors planted at random offsets and with headers that pass or fail
// each check. A scoreboard predicts the found or not-found beat of every
// table and compares each output beat against it, field by field.
// ============================================================================
module acpi_i2c_descriptor_scanner_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import acpi_scan_pkg::*;

    localparam int          ITEM_TARGET    = 1750;
    localparam int          HOLD_CYCLES    = 160;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          DRAIN_CYCLES   = 10;
    localparam logic [22:0] LEN_ALL_ONES   = 23'h7FFFFF;

    // Predicts the outcome of the scan and holds the beats still owed by the block.
    class scan_scoreboard;
        logic [7:0]  window [0:C_WIN_DEPTH-1];
        logic [22:0] position;
        bit          match_done;
        t_result     expected_reports [$];
        int          error_count;
        int          results_seen;

        function new();
            window       = '{default: 8'h00};
            position     = '0;
            match_done   = 1'b0;
            error_count  = 0;
            results_seen = 0;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        task report_mismatch(string what);
            $display("[%0t] MISMATCH: %s", $time, what);
            error_count++;
        endtask

        // Takes one accepted byte and queues the beat it should produce.
        function void note_byte(t_item it);
            logic [7:0]  span [0:C_WIN_DEPTH];
            int unsigned offset;
            int unsigned len;
            int unsigned payload;
            int unsigned type_len;
            int unsigned addr;
            bit          hit;
            t_result     r;

            if (it.first_byte) begin
                window     = '{default: 8'h00};
                position   = '0;
                match_done = 1'b0;
            end
            for (int k = 0; k < C_WIN_DEPTH; k++) begin
                span[k] = window[k];
            end
            span[C_WIN_DEPTH] = it.data_byte;

            // The span starting 17 bytes back is the candidate descriptor.
            len = 32'(it.table_length);
            hit = 1'b0;
            if (!match_done && position >= C_WIN_DEPTH) begin
                offset   = position - C_WIN_DEPTH;
                payload  = 32'({span[2], span[1]});
                type_len = 32'({span[11], span[10]});
                addr     = 32'({span[17], span[16]});
                hit = (len >= C_MIN_OFFSET) && (len <= C_MAX_TABLE_BYTES)
                    && (offset >= C_MIN_OFFSET) && (offset + 18 <= len)
                    && (span[0] == C_DESC_TAG)
                    && (payload >= C_MIN_PAYLOAD) && (offset + 3 + payload <= len)
                    && (span[5] == C_BUS_TYPE_I2C)
                    && (type_len >= C_MIN_TYPE_LEN)
                    && (addr >= C_ADDR_LOW) && (addr <= C_ADDR_HIGH);
            end
            if (hit) begin
                r.found         = 1'b1;
                r.slave_address = addr[6:0];
                expected_reports.push_back(r);
                match_done = 1'b1;
            end
            if (it.last_byte && !match_done) begin
                r.found         = 1'b0;
                r.slave_address = 7'd0;
                expected_reports.push_back(r);
            end
            if (it.last_byte) begin
                match_done = 1'b1;
            end

            for (int k = 0; k < C_WIN_DEPTH; k++) begin
                window[k] = span[k + 1];
            end
            if (position != LEN_ALL_ONES) begin
                position++;
            end
        endfunction

        // Compares one output beat with the oldest expectation.
        task check_result(t_result got);
            t_result want;
            results_seen++;
            if (expected_reports.size() == 0) begin
                report_mismatch($sformatf("unexpected beat found=%0d addr=0x%02h",
                                          got.found, got.slave_address));
            end else begin
                want = expected_reports.pop_front();
                if (got.found !== want.found) begin
                    report_mismatch($sformatf("found %0d, expected %0d",
                                              got.found, want.found));
                end
                if (got.slave_address !== want.slave_address) begin
                    report_mismatch($sformatf("slave_address 0x%02h, expected 0x%02h",
                                              got.slave_address, want.slave_address));
                end
            end
        endtask

        task flush_check();
            if (expected_reports.size() != 0) begin
                report_mismatch($sformatf("%0d expected beats never arrived",
                                          expected_reports.size()));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;

    acpi_scan_if #(.t_payload(t_item))   in_ch ();
    acpi_scan_if #(.t_payload(t_result)) out_ch ();

    acpi_i2c_descriptor_scanner_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    scan_scoreboard sb = new();

    bit sender_calm;
    bit hold_request;
    int sent_items;
    int idle_cycles;

    // Clock, 10 ns period.
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("acpi_i2c_descriptor_scanner_core_tb NOT OK");
            $finish;
        end
    end

    // Offers one input beat and waits for it to be taken.
    task send_byte(input logic [7:0] data, input logic [22:0] len,
                   input bit first, input bit last);
        int   gap;
        t_item it;
        gap = sender_calm ? 0 : $urandom_range(0, 11);
        repeat (gap) begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        it.data_byte    = data;
        it.table_length = len;
        it.first_byte   = first;
        it.last_byte    = last;
        in_ch.payload = it;
        in_ch.valid   = 1'b1;
        @(posedge clk);
        while (!in_ch.ready) begin
            @(posedge clk);
        end
        sb.note_byte(it);
        @(negedge clk);
        // The beat is gone; valid stays low until a following call raises it again.
        in_ch.valid = 1'b0;
    endtask

    // Sends one table with random bytes and planted descriptor headers.
    task run_table(input int n_bytes, input logic [22:0] decl_len, input int n_plant,
                   input bit mark_first, input bit mark_last, input bit jitter_len);
        logic [7:0]  body [];
        logic [22:0] len;
        int          o;
        int          limit;
        int unsigned payload;
        int unsigned type_len;
        int unsigned addr;

        body = new[n_bytes];
        foreach (body[k]) begin
            body[k] = 8'($urandom_range(0, 255));
        end

        // Each header passes most checks; one field is often pushed to an edge.
        for (int p = 0; p < n_plant; p++) begin
            if (n_bytes >= 52) begin
                o = ($urandom_range(0, 3) == 0) ? n_bytes - 18
                                                : $urandom_range(34, n_bytes - 18);
                limit = int'(decl_len) - o - 3;
                if (limit < 0) limit = 0;
                if (limit > 65535) limit = 65535;
                case ($urandom_range(0, 9))
                    0: payload = 14;
                    1: payload = 15;
                    2: payload = limit;
                    3: payload = (limit < 65535) ? limit + 1 : limit;
                    4: payload = $urandom_range(0, 65535);
                    default: payload = (limit < 15) ? 15
                                     : $urandom_range(15, (limit > 300) ? 300 : limit);
                endcase
                case ($urandom_range(0, 7))
                    0: type_len = 5;
                    1: type_len = 6;
                    2: type_len = $urandom_range(0, 65535);
                    default: type_len = $urandom_range(6, 65535);
                endcase
                case ($urandom_range(0, 11))
                    0: addr = 'h0007;
                    1: addr = 'h0008;
                    2: addr = 'h0077;
                    3: addr = 'h0078;
                    4: addr = $urandom_range(0, 65535);
                    default: addr = $urandom_range(8, 'h77);
                endcase
                body[o]      = C_DESC_TAG;
                body[o + 1]  = payload[7:0];
                body[o + 2]  = payload[15:8];
                body[o + 5]  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                           : C_BUS_TYPE_I2C;
                body[o + 10] = type_len[7:0];
                body[o + 11] = type_len[15:8];
                body[o + 16] = addr[7:0];
                body[o + 17] = addr[15:8];
            end
        end

        for (int k = 0; k < n_bytes; k++) begin
            len = decl_len;
            if (jitter_len && $urandom_range(0, 7) == 0) begin
                len = 23'($urandom_range(0, int'(decl_len) + 20));
            end
            send_byte(body[k], len, mark_first && k == 0, mark_last && k == n_bytes - 1);
            sent_items++;
        end
    endtask

    task wait_drained();
        while (sb.pending() != 0) begin
            @(negedge clk);
        end
    endtask

    // Receiver: random stalls per beat, with calm stretches and one long hold.
    initial begin : receiver
        int  gap;
        bit  recv_calm;
        out_ch.ready = 1'b0;
        recv_calm    = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (hold_request) begin
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end else begin
                if ($urandom_range(0, 15) == 0) recv_calm = !recv_calm;
                gap = recv_calm ? 0 : $urandom_range(0, 11);
                repeat (gap) begin
                    out_ch.ready = 1'b0;
                    @(negedge clk);
                end
            end
            out_ch.ready = 1'b1;
            @(posedge clk);
            while (!out_ch.valid && !hold_request) begin
                @(posedge clk);
            end
            if (out_ch.valid) begin
                sb.check_result(out_ch.payload);
            end
            @(negedge clk);
        end
    end

    // Main sequence: reset, directed tables, back-pressure, random tables.
    initial begin : stimulus
        int          kind;
        int          n_bytes;
        logic [22:0] decl_len;
        int          n_plant;
        bit          mark_first;
        bit          mark_last;
        bit          jitter_len;

        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        rst_n         = 1'b0;
        sender_calm   = 1'b0;
        hold_request  = 1'b0;
        sent_items    = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Single-byte tables at the length extremes.
        send_byte(8'hFF, LEN_ALL_ONES, 1'b1, 1'b1);
        send_byte(8'h00, 23'd0, 1'b1, 1'b1);
        // A table shorter than any descriptor offset, then bytes after its end.
        send_byte(C_DESC_TAG, 23'd5, 1'b1, 1'b0);
        send_byte(8'hFF, 23'd5, 1'b0, 1'b0);
        send_byte(8'h00, 23'd5, 1'b0, 1'b0);
        send_byte(C_BUS_TYPE_I2C, 23'd5, 1'b0, 1'b0);
        send_byte(8'hAA, 23'd5, 1'b0, 1'b1);
        send_byte(8'h55, 23'd36, 1'b0, 1'b0);
        send_byte(8'hAA, 23'd36, 1'b0, 1'b0);
        // A table cut off without its last marker, restarted by a new first byte.
        run_table(10, 23'd60, 0, 1'b1, 1'b0, 1'b0);
        run_table(3, C_MAX_TABLE_BYTES, 0, 1'b1, 1'b1, 1'b0);
        run_table(2, C_MAX_TABLE_BYTES + 23'd1, 0, 1'b1, 1'b1, 1'b0);

        // Back-pressure: the receiver holds off while one-byte tables pile up.
        wait_drained();
        hold_request = 1'b1;
        sender_calm  = 1'b1;
        for (int k = 0; k < 24; k++) begin
            send_byte(8'($urandom_range(0, 255)), 23'($urandom_range(0, 100)),
                      1'b1, 1'b1);
        end
        sender_calm = 1'b0;
        wait_drained();

        sent_items = 0;
        while (sent_items < ITEM_TARGET) begin
            kind        = $urandom_range(0, 99);
            sender_calm = ($urandom_range(0, 3) == 0);
            jitter_len  = ($urandom_range(0, 9) == 0);
            mark_first  = 1'b1;
            mark_last   = 1'b1;
            n_plant     = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 2);
            if (kind < 66) begin
                n_bytes  = $urandom_range(36, 110);
                decl_len = 23'(n_bytes);
            end else if (kind < 74) begin
                decl_len = 23'($urandom_range(36, 90));
                n_bytes  = int'(decl_len) + $urandom_range(1, 30);
            end else if (kind < 80) begin
                n_bytes  = $urandom_range(40, 100);
                decl_len = 23'($urandom_range(0, LEN_ALL_ONES));
            end else if (kind < 84) begin
                decl_len = 23'($urandom_range(0, 35));
                n_bytes  = $urandom_range(1, 80);
            end else if (kind < 88) begin
                n_bytes  = $urandom_range(54, 100);
                decl_len = 23'($urandom_range(C_MAX_TABLE_BYTES + 1, LEN_ALL_ONES));
            end else if (kind < 91) begin
                n_bytes  = 1;
                decl_len = 23'($urandom_range(0, LEN_ALL_ONES));
            end else if (kind < 96) begin
                n_bytes    = $urandom_range(20, 90);
                decl_len   = 23'($urandom_range(36, 120));
                mark_first = ($urandom_range(0, 1) == 0);
                mark_last  = !mark_first;
            end else begin
                n_bytes  = $urandom_range(150, 400);
                decl_len = 23'(n_bytes);
            end
            run_table(n_bytes, decl_len, n_plant, mark_first, mark_last, jitter_len);

            // Stray bytes after the end of a table are ignored by the block.
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(2, 6)) begin
                    send_byte(8'($urandom_range(0, 255)), decl_len, 1'b0, 1'b0);
                end
            end
            if ($urandom_range(0, 19) == 0) begin
                in_ch.valid = 1'b0;
                wait_drained();
            end
        end
        in_ch.valid = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        sb.flush_check();
        if (sb.error_count == 0) begin
            $display("acpi_i2c_descriptor_scanner_core_tb OK");
        end else begin
            $display("acpi_i2c_descriptor_scanner_core_tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/acpi_scan_pkg.sv
hw/rtl/acpi_scan_if.sv
hw/rtl/acpi_scan_front.sv
hw/rtl/acpi_scan_queue.sv
hw/rtl/acpi_i2c_descriptor_scanner_core.sv
bench/acpi_i2c_descriptor_scanner_core_tb.sv
